@@ hw/rtl/event_scheduler_interrupt_ack_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the event scheduler
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef EVENT_SCHEDULER_INTERRUPT_ACK_DEFINES_SVH
`define EVENT_SCHEDULER_INTERRUPT_ACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESIA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esia: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define ESIA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esia: next-cycle property violated");

`endif

@@ hw/rtl/esia_pkg.sv @@
// ---------------------------------------------------------------------------
// Event scheduler package
// Types and fixed codes shared by the event scheduler RTL.
// ---------------------------------------------------------------------------
package esia_pkg;

  localparam int SLOT_W   = 2;
  localparam int TIME_W   = 64;
  localparam int PERIOD_W = 32;
  localparam int IN_W     = 200;
  localparam int OUT_W    = 200;
  localparam int SLOTS    = 3;

  localparam logic [TIME_W-1:0] NEVER_TIME = '1;

  // Item kinds.
  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  // Event slots.
  localparam logic [SLOT_W-1:0] SLOT_TIMER = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_INT   = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_FRAME = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_NONE  = 2'd3;

  // Interrupt modes.
  localparam logic [1:0] IM0 = 2'd0;
  localparam logic [1:0] IM1 = 2'd1;
  localparam logic [1:0] IM2 = 2'd2;
  localparam logic [1:0] IM3 = 2'd3;

  // Acknowledge cycle counts and the mode 1 restart address.
  localparam logic [TIME_W-1:0] CYC_IM0 = 64'd11;
  localparam logic [TIME_W-1:0] CYC_IM1 = 64'd13;
  localparam logic [TIME_W-1:0] CYC_IM2 = 64'd19;
  localparam logic [15:0]       RST38_ADDR = 16'h0038;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] event_id;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] cycle_count;
    logic              iff_req;
    logic [1:0]        int_mode;
    logic [15:0]       stack_ptr;
    logic [15:0]       prog_counter;
    logic [7:0]        refresh;
    logic [15:0]       vector_word;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] next_id;
    logic [TIME_W-1:0] next_time;
    logic [TIME_W-1:0] cycle_count_out;
    logic              timer_fired;
    logic              accepted;
    logic [15:0]       new_pc;
    logic [15:0]       new_sp;
    logic [7:0]        new_refresh;
    logic              mem_write;
    logic [15:0]       mem_addr;
    logic [7:0]        mem_data;
    logic              last;
  } result_t;

endpackage

@@ hw/rtl/event_scheduler_interrupt_ack.sv @@
// ---------------------------------------------------------------------------
// Event scheduler with interrupt acknowledge
// Tracks three event due times and runs the processor interrupt acknowledge.
// ---------------------------------------------------------------------------
// Usage: each input transaction on the in_ channel is either a schedule item
// (in_tuser = 0), which sets the due time of one event slot, or a dispatch
// item (in_tuser = 1), which fires the earliest scheduled event. Every item
// produces one result transaction on the out_ channel, except an accepted
// interrupt in mode 1 or 2, which produces two: first the write of the high
// byte of PC, then the write of the low byte together with the summary.
// out_tlast marks the final result of an item and out_tuser flags a memory
// byte write. The timer period is loaded through the cfg_ channel, which is
// always ready and must only be written while the block is idle.
// An input transaction passes through the input register and then the
// result register before its first result appears. Throughput is one item
// per cycle while the receiver is ready; an item that pushes PC holds back
// the next one until its pending second result has moved to the output.
// Reset brings every slot to never, the earliest slot to none and the
// period to one. When the receiver stalls, the result is held, the input
// register keeps the next item, and in_tready drops once both are full.
// ---------------------------------------------------------------------------
`include "event_scheduler_interrupt_ack_defines.svh"

module event_scheduler_interrupt_ack (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata, low bit up: event_id[2], event_time[64], cycle_count[64],
  // iff_req[1], int_mode[2], stack_ptr[16], prog_counter[16],
  // vector_page[8], refresh[8], vector_word[16], zero fill[3].
  input  logic [esia_pkg::IN_W-1:0]      in_tdata,
  // in_tuser: kind[1].
  input  logic                           in_tuser,
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata, low bit up: next_id[2], next_time[64], cycle_count_out[64],
  // timer_fired[1], accepted[1], new_pc[16], new_sp[16], new_refresh[8],
  // mem_addr[16], mem_data[8], zero fill[4].
  output logic [esia_pkg::OUT_W-1:0]     out_tdata,
  // out_tuser: mem_write[1].
  output logic                           out_tuser,
  output logic                           out_tlast,
  // Configuration channel: timer_period.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [esia_pkg::PERIOD_W-1:0]  cfg_data
);

  import esia_pkg::*;

  // Architectural state.
  logic [TIME_W-1:0]   due_r [SLOTS];
  logic [TIME_W-1:0]   due_nxt [SLOTS];
  logic [SLOT_W-1:0]   earliest_slot_r;
  logic [SLOT_W-1:0]   earliest_slot_nxt;
  logic [TIME_W-1:0]   earliest_time_nxt;
  logic [PERIOD_W-1:0] period_r;

  // Input register and the two result registers.
  in_item_t hold_r;
  logic     hold_valid_r;
  result_t  out_r;
  logic     out_valid_r;
  result_t  pend_r;
  logic     pend_valid_r;

  // Datapath results for the item in the input register.
  logic        fired;
  logic        go;
  logic        pushes;
  logic [TIME_W-1:0] cyc_new;
  logic [15:0] pc_new;
  logic [15:0] sp_new;
  result_t     push_res;
  result_t     final_res;

  logic out_free;
  logic step;

  assign cfg_ready = 1'b1;

  // The result register can load when empty or when its transaction completes.
  // An item is processed only when no second result is waiting.
  assign out_free  = !out_valid_r || out_tready;
  assign step      = hold_valid_r && out_free && !pend_valid_r;
  assign in_tready = !hold_valid_r || step;

  // Slot updates for schedule and dispatch.
  always_comb begin
    due_nxt = due_r;
    fired   = 1'b0;
    go      = 1'b0;
    if (hold_r.kind == KIND_SCHEDULE) begin
      // A schedule to the none slot is dropped.
      if (hold_r.event_id != SLOT_NONE) begin
        due_nxt[hold_r.event_id] = hold_r.event_time;
      end
    end else begin
      unique case (earliest_slot_r)
        SLOT_TIMER: begin
          fired               = 1'b1;
          due_nxt[SLOT_TIMER] = due_r[SLOT_TIMER] + {{(TIME_W-PERIOD_W){1'b0}}, period_r};
          go                  = hold_r.iff_req && (due_r[SLOT_INT] == NEVER_TIME);
        end
        SLOT_INT: begin
          go = 1'b1;
        end
        SLOT_FRAME: begin
          due_nxt[SLOT_FRAME] = NEVER_TIME;
        end
        default: begin
        end
      endcase
    end
    if (go) begin
      due_nxt[SLOT_INT] = NEVER_TIME;
    end
  end

  // Earliest slot after the update; the lowest slot wins a tie.
  always_comb begin
    earliest_slot_nxt = SLOT_NONE;
    earliest_time_nxt = NEVER_TIME;
    for (int i = 0; i < SLOTS; i++) begin
      if (due_nxt[i] < earliest_time_nxt) begin
        earliest_slot_nxt = SLOT_W'(i);
        earliest_time_nxt = due_nxt[i];
      end
    end
  end

  // Interrupt acknowledge per mode.
  always_comb begin
    pushes  = 1'b0;
    cyc_new = hold_r.cycle_count;
    pc_new  = hold_r.prog_counter;
    if (go) begin
      unique case (hold_r.int_mode)
        IM0: begin
          cyc_new = hold_r.cycle_count + CYC_IM0;
        end
        IM1: begin
          cyc_new = hold_r.cycle_count + CYC_IM1;
          pushes  = 1'b1;
          pc_new  = RST38_ADDR;
        end
        IM2: begin
          cyc_new = hold_r.cycle_count + CYC_IM2;
          pushes  = 1'b1;
          pc_new  = hold_r.vector_word;
        end
        IM3: begin
        end
      endcase
    end
    sp_new = pushes ? (hold_r.stack_ptr - 16'd2) : hold_r.stack_ptr;
  end

  always_comb begin
    push_res           = '0;
    push_res.mem_write = 1'b1;
    push_res.mem_addr  = hold_r.stack_ptr - 16'd1;
    push_res.mem_data  = hold_r.prog_counter[15:8];
    push_res.last      = 1'b0;

    final_res.next_id         = earliest_slot_nxt;
    final_res.next_time       = earliest_time_nxt;
    final_res.cycle_count_out = cyc_new;
    final_res.timer_fired     = fired;
    final_res.accepted        = go;
    final_res.new_pc          = pc_new;
    final_res.new_sp          = sp_new;
    final_res.new_refresh     = go ? {hold_r.refresh[7], hold_r.refresh[6:0] + 7'd1}
                                   : hold_r.refresh;
    final_res.mem_write       = pushes;
    final_res.mem_addr        = pushes ? (hold_r.stack_ptr - 16'd2) : 16'd0;
    final_res.mem_data        = pushes ? hold_r.prog_counter[7:0] : 8'd0;
    final_res.last            = 1'b1;
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        due_r[i] <= NEVER_TIME;
      end
      earliest_slot_r <= SLOT_NONE;
      period_r        <= PERIOD_RESET;
      hold_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
      pend_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        hold_valid_r <= 1'b1;
      end else if (step) begin
        hold_valid_r <= 1'b0;
      end
      if (step) begin
        due_r           <= due_nxt;
        earliest_slot_r <= earliest_slot_nxt;
        out_valid_r     <= 1'b1;
        pend_valid_r    <= pushes;
      end else if (pend_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r.kind         <= in_tuser;
      hold_r.event_id     <= in_tdata[1:0];
      hold_r.event_time   <= in_tdata[65:2];
      hold_r.cycle_count  <= in_tdata[129:66];
      hold_r.iff_req      <= in_tdata[130];
      hold_r.int_mode     <= in_tdata[132:131];
      hold_r.stack_ptr    <= in_tdata[148:133];
      hold_r.prog_counter <= in_tdata[164:149];
      hold_r.refresh      <= in_tdata[180:173];
      hold_r.vector_word  <= in_tdata[196:181];
    end
    if (step) begin
      out_r  <= pushes ? push_res : final_res;
      pend_r <= final_res;
    end else if (pend_valid_r && out_free) begin
      out_r <= pend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.mem_write;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {4'd0, out_r.mem_data, out_r.mem_addr, out_r.new_refresh,
                       out_r.new_sp, out_r.new_pc, out_r.accepted, out_r.timer_fired,
                       out_r.cycle_count_out, out_r.next_time, out_r.next_id};

  // A second result only waits behind a first one still on the output.
  `ESIA_ASSERT_IMP(a_pend_behind_out, pend_valid_r, out_valid_r)
  // A non-final result is the high-byte push, so its low-byte result waits.
  `ESIA_ASSERT_IMP(a_first_has_pend, out_valid_r && !out_r.last,
                   pend_valid_r && out_r.mem_write)
  // No earliest slot means every slot is never.
  `ESIA_ASSERT_IMP(a_none_all_never, earliest_slot_r == SLOT_NONE,
                   (due_r[SLOT_TIMER] == NEVER_TIME) && (due_r[SLOT_INT] == NEVER_TIME) &&
                   (due_r[SLOT_FRAME] == NEVER_TIME))
  // Dispatching an interrupt event always clears its slot.
  `ESIA_ASSERT_NXT(a_int_cleared,
                   step && (hold_r.kind == KIND_DISPATCH) && (earliest_slot_r == SLOT_INT),
                   due_r[SLOT_INT] == NEVER_TIME)
  // An item in the input register is never dropped without being processed.
  `ESIA_ASSERT_NXT(a_hold_kept, hold_valid_r && !step, hold_valid_r)

endmodule

@@ tb/sv/event_scheduler_checker.sv @@
// ---------------------------------------------------------------------------
// Event scheduler result checker
// Watches the input, result and configuration channels of the event
// scheduler, predicts every result transaction and compares it field by
// field with what the block delivers.
// ---------------------------------------------------------------------------
module event_scheduler_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [esia_pkg::IN_W-1:0]     in_tdata,
  input  logic                          in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [esia_pkg::OUT_W-1:0]    out_tdata,
  input  logic                          out_tuser,
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [esia_pkg::PERIOD_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            results_due
);

  import esia_pkg::*;

  // Shadow copy of the scheduler state.
  logic [TIME_W-1:0]   due_at [SLOTS];
  logic [SLOT_W-1:0]   soonest_slot;
  logic [TIME_W-1:0]   soonest_time;
  logic [PERIOD_W-1:0] timer_reload;

  result_t scheduler_outcomes [$];
  int      results_seen;

  function automatic void rescan_due_times();
    soonest_slot = SLOT_NONE;
    soonest_time = NEVER_TIME;
    for (int s = 0; s < SLOTS; s++) begin
      // Strict compare keeps the lowest slot on a tie.
      if (due_at[s] < soonest_time) begin
        soonest_slot = SLOT_W'(s);
        soonest_time = due_at[s];
      end
    end
  endfunction

  task automatic advance_scheduler(
    input logic              kind,
    input logic [SLOT_W-1:0] slot_sel,
    input logic [TIME_W-1:0] new_due,
    input logic [TIME_W-1:0] cyc_in,
    input logic              int_en,
    input logic [1:0]        mode,
    input logic [15:0]       sp_in,
    input logic [15:0]       pc_in,
    input logic [7:0]        r_in,
    input logic [15:0]       vword
  );
    result_t           summary;
    result_t           push_hi;
    logic [TIME_W-1:0] cyc;
    logic [15:0]       pc;
    logic [15:0]       sp;
    logic [7:0]        r;
    logic              fired;
    logic              took;
    logic              pushes;
    logic              go;
    cyc    = cyc_in;
    pc     = pc_in;
    sp     = sp_in;
    r      = r_in;
    fired  = 1'b0;
    took   = 1'b0;
    pushes = 1'b0;
    go     = 1'b1;
    if (kind == KIND_SCHEDULE) begin
      if (slot_sel != SLOT_NONE) due_at[slot_sel] = new_due;
      rescan_due_times();
    end else if (soonest_slot == SLOT_FRAME) begin
      due_at[SLOT_FRAME] = NEVER_TIME;
      rescan_due_times();
    end else if (soonest_slot != SLOT_NONE) begin
      if (soonest_slot == SLOT_TIMER) begin
        fired = 1'b1;
        due_at[SLOT_TIMER] = due_at[SLOT_TIMER] + {32'd0, timer_reload};
        rescan_due_times();
        go = int_en && (due_at[SLOT_INT] == NEVER_TIME);
      end
      if (go) begin
        took = 1'b1;
        case (mode)
          IM0: cyc += CYC_IM0;
          IM1: begin
            cyc += CYC_IM1;
            pushes = 1'b1;
            pc = RST38_ADDR;
          end
          IM2: begin
            cyc += CYC_IM2;
            pushes = 1'b1;
            pc = vword;
          end
          default: ;
        endcase
        if (pushes) sp = sp_in - 16'd2;
        r = {r_in[7], r_in[6:0] + 7'd1};
        due_at[SLOT_INT] = NEVER_TIME;
        rescan_due_times();
      end
    end

    if (pushes) begin
      push_hi = '0;
      push_hi.mem_write = 1'b1;
      push_hi.mem_addr  = sp_in - 16'd1;
      push_hi.mem_data  = pc_in[15:8];
      scheduler_outcomes.push_back(push_hi);
    end
    summary = '0;
    summary.next_id         = soonest_slot;
    summary.next_time       = soonest_time;
    summary.cycle_count_out = cyc;
    summary.timer_fired     = fired;
    summary.accepted        = took;
    summary.new_pc          = pc;
    summary.new_sp          = sp;
    summary.new_refresh     = r;
    summary.mem_write       = pushes;
    if (pushes) begin
      summary.mem_addr = sp_in - 16'd2;
      summary.mem_data = pc_in[7:0];
    end
    summary.last = 1'b1;
    scheduler_outcomes.push_back(summary);
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d: %s expected %h, got %h", results_seen, fname, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (scheduler_outcomes.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d arrived with nothing expected", results_seen);
    end else begin
      want = scheduler_outcomes.pop_front();
      check_field("next_id",         64'(want.next_id),     64'(out_tdata[1:0]));
      check_field("next_time",       want.next_time,        out_tdata[65:2]);
      check_field("cycle_count_out", want.cycle_count_out,  out_tdata[129:66]);
      check_field("timer_fired",     64'(want.timer_fired), 64'(out_tdata[130]));
      check_field("accepted",        64'(want.accepted),    64'(out_tdata[131]));
      check_field("new_pc",          64'(want.new_pc),      64'(out_tdata[147:132]));
      check_field("new_sp",          64'(want.new_sp),      64'(out_tdata[163:148]));
      check_field("new_refresh",     64'(want.new_refresh), 64'(out_tdata[171:164]));
      check_field("mem_write",       64'(want.mem_write),   64'(out_tuser));
      check_field("mem_addr",        64'(want.mem_addr),    64'(out_tdata[187:172]));
      check_field("mem_data",        64'(want.mem_data),    64'(out_tdata[195:188]));
      check_field("last",            64'(want.last),        64'(out_tlast));
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) due_at[s] = NEVER_TIME;
      soonest_slot = SLOT_NONE;
      soonest_time = NEVER_TIME;
      timer_reload = PERIOD_RESET;
      scheduler_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) timer_reload = cfg_data;
      // A result can never belong to an input taken at the same edge.
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready)
        advance_scheduler(in_tuser, in_tdata[1:0], in_tdata[65:2], in_tdata[129:66],
                          in_tdata[130], in_tdata[132:131], in_tdata[148:133],
                          in_tdata[164:149], in_tdata[180:173], in_tdata[196:181]);
    end
    results_due = scheduler_outcomes.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// Event scheduler testbench
// Drives schedule and dispatch transactions into the event scheduler with
// interrupt acknowledge, varies the timer period between phases and lets a
// checker module predict and compare every result transaction.
// ---------------------------------------------------------------------------
module testbench;
  import esia_pkg::*;

  // One input transaction, field by field, before packing onto in_tdata.
  typedef struct {
    logic              kind;
    logic [SLOT_W-1:0] event_id;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] cycle_count;
    logic              iff_req;
    logic [1:0]        int_mode;
    logic [15:0]       stack_ptr;
    logic [15:0]       prog_counter;
    logic [7:0]        vector_page;
    logic [7:0]        refresh;
    logic [15:0]       vector_word;
  } sched_item_t;

  // Every input of the block holds a known value from time zero on.
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  wire                 in_tready;
  logic [IN_W-1:0]     in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  wire                 out_tvalid;
  logic                out_tready = 1'b0;
  wire  [OUT_W-1:0]    out_tdata;
  wire                 out_tuser;
  wire                 out_tlast;
  logic                cfg_valid  = 1'b0;
  wire                 cfg_ready;
  logic [PERIOD_W-1:0] cfg_data   = '0;

  int fail_count;
  int results_due;

  // Idle rates in percent per cycle, changed between phases.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // The stimulus bumps hold_requests to ask the receiver for one long stall.
  int hold_requests = 0;
  int holds_served  = 0;
  int rx_hold_left  = 0;

  // Running notion of the current cycle, so that most scheduled times land
  // close together and events actually get dispatched in order.
  logic [TIME_W-1:0] horizon = '0;

  event_scheduler_interrupt_ack dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  event_scheduler_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always #10 clk = ~clk;

  // Receiver side. Normally ready is drawn per cycle from the current idle
  // rate; when a long stall is requested, ready is held low long enough that
  // the result register and the input register both fill up and the block
  // has to drop in_tready while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      rx_hold_left = 400;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Draws one item. Scheduled times are mostly near the horizon, with some
  // never, some just below never (so a timer reload wraps past the top) and
  // some fully random. Slot three and mode three show up now and then.
  function automatic sched_item_t random_item(input logic [TIME_W-1:0] around);
    sched_item_t it;
    int          pick;
    it.kind     = ($urandom_range(99) < 55) ? KIND_DISPATCH : KIND_SCHEDULE;
    it.event_id = ($urandom_range(99) < 5) ? SLOT_NONE : SLOT_W'($urandom_range(2));
    pick = $urandom_range(99);
    if (pick < 10)      it.event_time = NEVER_TIME;
    else if (pick < 18) it.event_time = NEVER_TIME - $urandom_range(40);
    else if (pick < 28) it.event_time = {$urandom, $urandom};
    else                it.event_time = around + $urandom_range(3000);
    it.cycle_count  = ($urandom_range(3) == 0) ? NEVER_TIME - $urandom_range(20)
                                               : {$urandom, $urandom};
    it.iff_req      = ($urandom_range(3) != 0);
    it.int_mode     = ($urandom_range(9) == 0) ? IM3 : 2'($urandom_range(2));
    it.stack_ptr    = 16'($urandom);
    it.prog_counter = 16'($urandom);
    it.vector_page  = 8'($urandom);
    it.refresh      = 8'($urandom);
    it.vector_word  = 16'($urandom);
    return it;
  endfunction

  // A directed item: the fields that matter are given, the rest are random.
  function automatic sched_item_t make_item(input logic kind, input logic [SLOT_W-1:0] slot_sel,
                                            input logic [TIME_W-1:0] due);
    sched_item_t it;
    it            = random_item('0);
    it.kind       = kind;
    it.event_id   = slot_sel;
    it.event_time = due;
    return it;
  endfunction

  // Offers one item and returns at the edge where the transaction happens.
  // Idle cycles are inserted before the item, so in_tvalid is only lowered
  // when a gap is actually taken and never toggled within one step.
  task automatic send_item(input sched_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {3'b000, it.vector_word, it.refresh, it.vector_page, it.prog_counter,
                  it.stack_ptr, it.int_mode, it.iff_req, it.cycle_count, it.event_time,
                  it.event_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every expected result has been taken,
  // then a few more cycles so the block is fully idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_period(input logic [PERIOD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic. Every so often the sender drains the block completely
  // before going on, which also puts gaps on every phase of its work.
  task automatic random_run(input int count);
    sched_item_t it;
    for (int k = 0; k < count; k++) begin
      it = random_item(horizon);
      if (it.kind == KIND_DISPATCH) horizon += $urandom_range(2000);
      send_item(it);
      if (k % 150 == 149) settle();
    end
  endtask

  task automatic directed_run();
    sched_item_t it;
    // Dispatch with nothing scheduled: every field must pass through, here
    // with the cycle count, stack pointer, PC and R at their top values.
    it = make_item(KIND_DISPATCH, SLOT_TIMER, '0);
    it.cycle_count  = NEVER_TIME;
    it.stack_ptr    = 16'hFFFF;
    it.prog_counter = 16'hFFFF;
    it.refresh      = 8'hFF;
    send_item(it);
    // A schedule to slot three is ignored, so the next dispatch still
    // finds nothing scheduled.
    send_item(make_item(KIND_SCHEDULE, SLOT_NONE, 64'd5));
    send_item(make_item(KIND_DISPATCH, SLOT_TIMER, '0));
    // All three slots due at zero: the timer wins the tie.
    send_item(make_item(KIND_SCHEDULE, SLOT_TIMER, '0));
    send_item(make_item(KIND_SCHEDULE, SLOT_INT, '0));
    send_item(make_item(KIND_SCHEDULE, SLOT_FRAME, '0));
    // Timer fires while the interrupt slot is pending: no acceptance.
    it = make_item(KIND_DISPATCH, SLOT_TIMER, '0);
    it.iff_req = 1'b1;
    send_item(it);
    // Interrupt beats end of frame on the tie; mode 1 with the stack
    // pointer and the cycle count wrapping, and R keeping bit 7.
    it = make_item(KIND_DISPATCH, SLOT_TIMER, '0);
    it.int_mode     = IM1;
    it.stack_ptr    = 16'h0000;
    it.prog_counter = 16'hABCD;
    it.cycle_count  = NEVER_TIME - 64'd5;
    it.refresh      = 8'hFF;
    send_item(it);
    // End of frame is cleared.
    send_item(make_item(KIND_DISPATCH, SLOT_TIMER, '0));
    // Timer fires with no interrupt pending: mode 2 acceptance through the
    // vector word, with the push wrapping below address zero.
    it = make_item(KIND_DISPATCH, SLOT_TIMER, '0);
    it.iff_req     = 1'b1;
    it.int_mode    = IM2;
    it.stack_ptr   = 16'h0001;
    it.refresh     = 8'h7F;
    it.vector_word = 16'h1234;
    send_item(it);
    // Interrupts disabled: the timer fires but nothing is accepted.
    it = make_item(KIND_DISPATCH, SLOT_TIMER, '0);
    it.iff_req = 1'b0;
    send_item(it);
    // Mode 0 and then the undefined mode three.
    it = make_item(KIND_DISPATCH, SLOT_TIMER, '0);
    it.iff_req  = 1'b1;
    it.int_mode = IM0;
    send_item(it);
    it = make_item(KIND_DISPATCH, SLOT_TIMER, '0);
    it.iff_req  = 1'b1;
    it.int_mode = IM3;
    send_item(it);
    // A reload that lands on all ones leaves nothing scheduled.
    send_item(make_item(KIND_SCHEDULE, SLOT_TIMER, NEVER_TIME - 64'd1));
    it = make_item(KIND_DISPATCH, SLOT_TIMER, '0);
    it.iff_req = 1'b0;
    send_item(it);
    send_item(make_item(KIND_DISPATCH, SLOT_TIMER, '0));
    // Timer and end of frame tie ahead of a pending interrupt.
    send_item(make_item(KIND_SCHEDULE, SLOT_INT, 64'd100));
    send_item(make_item(KIND_SCHEDULE, SLOT_FRAME, 64'd50));
    send_item(make_item(KIND_SCHEDULE, SLOT_TIMER, 64'd50));
    it = make_item(KIND_DISPATCH, SLOT_TIMER, '0);
    it.iff_req = 1'b1;
    send_item(it);
    send_item(make_item(KIND_DISPATCH, SLOT_TIMER, '0));
    // Back to an empty schedule for the random phases.
    send_item(make_item(KIND_SCHEDULE, SLOT_INT, NEVER_TIME));
    send_item(make_item(KIND_SCHEDULE, SLOT_TIMER, NEVER_TIME));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Period register written right after reset, with its reset value of one.
    load_period(PERIOD_RESET);
    directed_run();
    settle();

    // Phase one: sender rarely idle, receiver mostly stalled.
    load_period(PERIOD_W'($urandom_range(65535, 1)));
    tx_idle_pct = 10;
    rx_idle_pct = 83;
    random_run(380);
    settle();

    // Phase two: the other way round, with the period at its top value.
    load_period({PERIOD_W{1'b1}});
    tx_idle_pct = 83;
    rx_idle_pct = 10;
    random_run(380);
    settle();

    // Phase three: no idling at all, a short period so the timer fires
    // often, and one long receiver stall right at the start while the
    // sender keeps pushing transactions.
    load_period(PERIOD_W'($urandom_range(1000, 1)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    random_run(380);
    settle();

    if (fail_count == 0 && results_due == 0) begin
      $display("[event_scheduler_interrupt_ack] OK");
    end else begin
      $display("[event_scheduler_interrupt_ack] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(20 * 400000);
    $display("[event_scheduler_interrupt_ack] ERROR");
    $finish;
  end

endmodule
